// File: rtl/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared constants and types for the remote command frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

   // Field limit: fields at this index and above are ignored.
   localparam int MAX_FIELDS  = 7;
   localparam int FIELD_IDX_W = $clog2(MAX_FIELDS + 1);
   // Data bytes carried by one result.
   localparam int NUM_BYTES   = 6;

   localparam logic [7:0] SEP_BYTE   = 8'h7C;  // '|'
   localparam logic [7:0] END_BYTE   = 8'h26;  // '&'
   localparam logic [7:0] PLUS_BYTE  = 8'h2B;  // '+'
   localparam logic [7:0] MINUS_BYTE = 8'h2D;  // '-'
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] TAB_BYTE   = 8'h09;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] ZERO_BYTE  = 8'h30;  // '0'
   localparam logic [7:0] NINE_BYTE  = 8'h39;  // '9'

   localparam logic [7:0] KEY_MOVE    = 8'h43;  // 'C'
   localparam logic [7:0] KEY_ARM     = 8'h44;  // 'D'
   localparam logic [7:0] KEY_POSE    = 8'h46;  // 'F'
   localparam logic [7:0] KEY_RGB     = 8'h48;  // 'H'
   localparam logic [7:0] KEY_AVOID   = 8'h49;  // 'I'
   localparam logic [7:0] KEY_BALANCE = 8'h4A;  // 'J'
   localparam logic [7:0] KEY_ACTION  = 8'h4B;  // 'K'
   localparam logic [7:0] KEY_RESET   = 8'h4F;  // 'O'

   typedef enum logic [3:0] {
      CMD_NULL    = 4'd0,
      CMD_MOVE    = 4'd1,
      CMD_ARM     = 4'd2,
      CMD_POSE    = 4'd3,
      CMD_RGB     = 4'd4,
      CMD_AVOID   = 4'd5,
      CMD_BALANCE = 4'd6,
      CMD_ACTION  = 4'd7,
      CMD_RESET   = 4'd8
   } cmd_type;

   // Number scanner phase, one-hot.
   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   // Frame as it stands with the current field closed out.
   typedef struct packed {
      logic [7:0]                 key_char;
      logic [1:0]                 key_length;
      logic                       sub_is_one;
      logic [NUM_BYTES-1:0][7:0]  field_bytes;
   } frame_type;

   typedef struct packed {
      cmd_type                    command;
      logic [NUM_BYTES-1:0][7:0]  values;
   } result_type;

endpackage

// File: rtl/rcfp_tokenizer.sv
// ----------------------------------------------------------------------------
// rcfp_tokenizer
// Per-byte frame state: key capture, field counting and atoi-style number
// scanning. Presents the frame with its open field closed out.
// ----------------------------------------------------------------------------
module rcfp_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   output rcfp_pkg::frame_type frame
);
   import rcfp_pkg::*;

   logic [FIELD_IDX_W-1:0]    field_index_ff, field_index_in;
   logic [7:0]                key_char_ff, key_char_in;
   logic [1:0]                key_length_ff, key_length_in;
   phase_type                 phase_ff, phase_in;
   logic                      negative_ff, negative_in;
   logic [15:0]               magnitude_ff, magnitude_in;
   logic [NUM_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic                      sub_is_one_ff, sub_is_one_in;

   logic                      is_sep, is_end, is_digit, is_space, is_sign;
   logic                      in_number, take_digit;
   logic [3:0]                digit;
   logic [19:0]               mag_wide;
   logic [NUM_BYTES-1:0]      lane_hit;
   logic [NUM_BYTES-1:0][7:0] bytes_closed;
   logic                      sub_now;

   assign is_sep   = (data_byte == SEP_BYTE);
   assign is_end   = (data_byte == END_BYTE);
   assign is_digit = (data_byte >= ZERO_BYTE) && (data_byte <= NINE_BYTE);
   assign is_space = ((data_byte >= TAB_BYTE) && (data_byte <= CR_BYTE)) ||
                     (data_byte == SPACE_BYTE);
   assign is_sign  = (data_byte == PLUS_BYTE) || (data_byte == MINUS_BYTE);
   assign digit    = data_byte[3:0];
   assign in_number = (field_index_ff != '0) &&
                      (field_index_ff < FIELD_IDX_W'(MAX_FIELDS));

   // Lane i holds the low byte of field i+1.
   always_comb begin
      for (int i = 0; i < NUM_BYTES; i++) begin
         lane_hit[i] = ((i + 1) < MAX_FIELDS) &&
                       (field_index_ff == FIELD_IDX_W'(i + 1));
         bytes_closed[i] = (lane_hit[i] && negative_ff) ? (8'd0 - bytes_ff[i])
                                                        : bytes_ff[i];
      end
   end

   assign sub_now = (field_index_ff == FIELD_IDX_W'(1)) ?
                    (!negative_ff && (magnitude_ff == 16'd1)) : sub_is_one_ff;

   assign frame.key_char    = key_char_ff;
   assign frame.key_length  = key_length_ff;
   assign frame.sub_is_one  = sub_now;
   assign frame.field_bytes = bytes_closed;

   assign mag_wide = {4'b0000, magnitude_ff} * 20'd10 + {16'd0, digit};

   always_comb begin
      field_index_in = field_index_ff;
      key_char_in    = key_char_ff;
      key_length_in  = key_length_ff;
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      magnitude_in   = magnitude_ff;
      bytes_in       = bytes_ff;
      sub_is_one_in  = sub_is_one_ff;
      take_digit     = 1'b0;

      if (step) begin
         priority if (is_end) begin
            field_index_in = '0;
            key_char_in    = '0;
            key_length_in  = '0;
            phase_in       = PH_SKIP;
            negative_in    = 1'b0;
            magnitude_in   = '0;
            bytes_in       = '0;
            sub_is_one_in  = 1'b0;
         end else if (is_sep) begin
            bytes_in      = bytes_closed;
            sub_is_one_in = sub_now;
            phase_in      = PH_SKIP;
            negative_in   = 1'b0;
            magnitude_in  = '0;
            if (field_index_ff < FIELD_IDX_W'(MAX_FIELDS))
               field_index_in = field_index_ff + FIELD_IDX_W'(1);
         end else if (field_index_ff == '0) begin
            key_char_in = data_byte;
            if (key_length_ff < 2'd2)
               key_length_in = key_length_ff + 2'd1;
         end else if (in_number) begin
            unique case (phase_ff)
               PH_SKIP: begin
                  priority if (is_space) begin
                  end else if (is_sign) begin
                     negative_in = (data_byte == MINUS_BYTE);
                     phase_in    = PH_DIGITS;
                  end else if (!is_digit) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in   = PH_DIGITS;
                     take_digit = 1'b1;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit)
                     take_digit = 1'b1;
                  else
                     phase_in = PH_DONE;
               end
               PH_DONE: begin
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
            if (take_digit) begin
               magnitude_in = (mag_wide > 20'h0FFFF) ? 16'hFFFF : mag_wide[15:0];
               for (int i = 0; i < NUM_BYTES; i++) begin
                  if (lane_hit[i])
                     bytes_in[i] = bytes_ff[i] * 8'd10 + {4'b0000, digit};
               end
            end
         end else begin
            // fields past the limit: ignored
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= '0;
         key_char_ff    <= '0;
         key_length_ff  <= '0;
         phase_ff       <= PH_SKIP;
         negative_ff    <= 1'b0;
         magnitude_ff   <= '0;
         bytes_ff       <= '0;
         sub_is_one_ff  <= 1'b0;
      end else begin
         field_index_ff <= field_index_in;
         key_char_ff    <= key_char_in;
         key_length_ff  <= key_length_in;
         phase_ff       <= phase_in;
         negative_ff    <= negative_in;
         magnitude_ff   <= magnitude_in;
         bytes_ff       <= bytes_in;
         sub_is_one_ff  <= sub_is_one_in;
      end
   end

endmodule

// File: rtl/rcfp_cmd_decode.sv
// ----------------------------------------------------------------------------
// rcfp_cmd_decode
// Maps a closed frame to its command code and the data bytes it carries.
// ----------------------------------------------------------------------------
module rcfp_cmd_decode (
   input  rcfp_pkg::frame_type  frame,
   output rcfp_pkg::result_type result
);
   import rcfp_pkg::*;

   cmd_type    command;
   logic [2:0] num_used;

   always_comb begin
      command  = CMD_NULL;
      num_used = 3'd0;
      if (frame.key_length == 2'd1) begin
         unique case (frame.key_char)
            KEY_MOVE:    begin command = CMD_MOVE;    num_used = 3'd3; end
            KEY_ARM:     begin command = CMD_ARM;                      end
            KEY_POSE:    begin command = CMD_POSE;    num_used = 3'd6; end
            KEY_RGB:     begin command = CMD_RGB;     num_used = 3'd3; end
            KEY_AVOID:   begin command = CMD_AVOID;   num_used = 3'd1; end
            KEY_BALANCE: begin command = CMD_BALANCE; num_used = 3'd1; end
            KEY_ACTION:  begin
               if (frame.sub_is_one)
                  command = CMD_ACTION;
            end
            KEY_RESET:   begin command = CMD_RESET;                    end
            default:     begin                                         end
         endcase
      end
   end

   always_comb begin
      result.command = command;
      for (int i = 0; i < NUM_BYTES; i++)
         result.values[i] = (3'(i) < num_used) ? frame.field_bytes[i] : 8'd0;
      // action group carries field 2 in the first byte
      if (command == CMD_ACTION)
         result.values[0] = frame.field_bytes[1];
   end

endmodule

// File: rtl/remote_command_frame_parser.sv
// ----------------------------------------------------------------------------
// remote_command_frame_parser
// Parses '|'-separated, '&'-terminated text command frames into a command
// code and up to six data bytes.
// ----------------------------------------------------------------------------
//
//   channel | ports                           | item
//   --------+---------------------------------+------------------------------
//   req     | req_valid/req_ready/req_data_*  | one received text byte
//   rsp     | rsp_valid/rsp_ready/rsp_*       | command + six data bytes
//
// Flow: a byte is captured in the input register and from there updates
//   the frame state; an '&' loads the result register, which drives
//   rsp_valid. One byte per cycle while req_ready stays high.
// Stalls: only an '&' needs the result register. While a result waits and
//   an '&' sits in the input register, req_ready drops; other bytes flow on.
// Reset: synchronous, active high; clears all frame state and both valids.
//
// Frame rules:
//   - field 0 is a single key letter: C, D, F, H, I, J, K or O
//   - later fields are read like atoi: skip whitespace, optional sign,
//     digits until the first non-digit; rest of field ignored
//   - data byte = low byte of the signed field value; missing fields are 0
//   - K needs field 1 equal to exactly 1, and then sends field 2
//   - a 16-bit saturating magnitude tracks field 1 for the K test
//   - fields past the seventh are ignored
//
module remote_command_frame_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_command,
   output logic [7:0] rsp_value_a,
   output logic [7:0] rsp_value_b,
   output logic [7:0] rsp_value_c,
   output logic [7:0] rsp_value_d,
   output logic [7:0] rsp_value_e,
   output logic [7:0] rsp_value_f
);
   import rcfp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_command_ff, rsp_command_in;
   logic [NUM_BYTES-1:0][7:0] rsp_values_ff, rsp_values_in;

   logic       in_is_end;
   logic       advance;
   frame_type  frame;
   result_type result;

   assign in_is_end = (in_byte_ff == END_BYTE);

   // The held byte retires unless it is an '&' facing a full result register that is not being read.
   assign advance   = in_valid_ff && (!in_is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   rcfp_tokenizer u_tokenizer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .frame     (frame)
   );

   rcfp_cmd_decode u_cmd_decode (
      .frame  (frame),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_command_in = rsp_command_ff;
      rsp_values_in  = rsp_values_ff;
      priority if (advance && in_is_end) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = result.command;
         rsp_values_in  = result.values;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         // result holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      rsp_command_ff <= rsp_command_in;
      rsp_values_ff  <= rsp_values_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_value_a = rsp_values_ff[0];
   assign rsp_value_b = rsp_values_ff[1];
   assign rsp_value_c = rsp_values_ff[2];
   assign rsp_value_d = rsp_values_ff[3];
   assign rsp_value_e = rsp_values_ff[4];
   assign rsp_value_f = rsp_values_ff[5];

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // back-pressure only comes from an '&' blocked by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready && in_is_end))
      else $error("input stalled without a blocked end byte");

   // frame state is back to empty after an end byte retires
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && in_is_end) |=>
         (frame.key_length == 2'd0 && frame.field_bytes == '0 && !frame.sub_is_one))
      else $error("frame state not cleared after end byte");

   // commands without data carry all-zero bytes
   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_command_ff == CMD_NULL || rsp_command_ff == CMD_ARM ||
                        rsp_command_ff == CMD_RESET)) |-> (rsp_values_ff == '0))
      else $error("data bytes set on a command without data");

   // command code stays in range
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_command_ff <= CMD_RESET))
      else $error("command code out of range");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remote command frame parser. Text frames, both
// hand-written corner cases and random ones, are fed in byte by byte. A local
// decoder works out the command each '&' should give, and every result is
// checked field by field against it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import rcfp_pkg::*;

   // Run shape
   localparam int BYTE_TARGET    = 1700;   // stop adding random frames here
   localparam int HOLD_AT_RESULT = 25;     // long receiver hold starts here
   localparam int LONG_HOLD      = 300;    // cycles of that hold
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving
   localparam int TAIL_CYCLES    = 10;     // room after the drain before finishing
   localparam int PRINT_LIMIT    = 40;

   localparam logic [7:0] KEY_LIST [8] = '{KEY_MOVE, KEY_ARM, KEY_POSE, KEY_RGB,
                                           KEY_AVOID, KEY_BALANCE, KEY_ACTION,
                                           KEY_RESET};

   // One expected command and its six data bytes; vals[0] is value_a.
   typedef struct packed {
      cmd_type         command;
      logic [5:0][7:0] vals;
   } frame_result_t;

   // One text byte to send; wait_idle holds it back until nothing is pending.
   typedef struct {
      logic [7:0] data;
      bit         wait_idle;
   } text_byte_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_command;
   logic [7:0] rsp_value_a, rsp_value_b, rsp_value_c;
   logic [7:0] rsp_value_d, rsp_value_e, rsp_value_f;

   remote_command_frame_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_command   (rsp_command),
      .rsp_value_a   (rsp_value_a),
      .rsp_value_b   (rsp_value_b),
      .rsp_value_c   (rsp_value_c),
      .rsp_value_d   (rsp_value_d),
      .rsp_value_e   (rsp_value_e),
      .rsp_value_f   (rsp_value_f)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------------
   text_byte_t    text_bytes[$];        // bytes still to send
   frame_result_t pending_results[$];   // commands decoded, not yet seen
   int            total_bytes;
   int            total_frames;
   int            bytes_sent;
   int            results_seen;
   int            mismatches;
   int            cmd_seen [9];

   // ------------------------------------------------------------------------
   // Decoder state: mirrors the frame being parsed
   // ------------------------------------------------------------------------
   int         fld_idx;       // current field, stops at MAX_FIELDS
   logic [7:0] key_byte;      // last byte seen in field 0
   int         key_len;       // bytes in field 0, stops at two
   phase_type  scan_phase;    // atoi scanner: skip space, digits, done
   logic       neg_sign;
   logic [15:0] mag;          // saturating magnitude, used for the K test
   logic [7:0] fbytes [6];    // low bytes of fields 1..6
   logic       sub_one;       // field 1 was exactly +1

   function automatic void clear_decoder();
      fld_idx    = 0;
      key_byte   = 8'h00;
      key_len    = 0;
      scan_phase = PH_SKIP;
      neg_sign   = 1'b0;
      mag        = 16'h0000;
      for (int i = 0; i < 6; i++) fbytes[i] = 8'h00;
      sub_one    = 1'b0;
   endfunction

   // Fields 1..6 carry a data byte, unless the field limit cuts them off.
   function automatic bit holds_byte(int f);
      return f >= 1 && f <= 6 && f < MAX_FIELDS;
   endfunction

   function automatic void close_field();
      if (holds_byte(fld_idx) && neg_sign)
         fbytes[fld_idx-1] = 8'h00 - fbytes[fld_idx-1];
      if (fld_idx == 1)
         sub_one = !neg_sign && mag == 16'd1;
      scan_phase = PH_SKIP;
      neg_sign   = 1'b0;
      mag        = 16'h0000;
   endfunction

   function automatic void scan_number_byte(logic [7:0] c);
      bit is_digit;
      bit is_space;
      int m;
      is_digit = c >= ZERO_BYTE && c <= NINE_BYTE;
      is_space = (c >= TAB_BYTE && c <= CR_BYTE) || c == SPACE_BYTE;
      if (scan_phase == PH_SKIP) begin
         if (is_space) return;
         if (c == PLUS_BYTE || c == MINUS_BYTE) begin
            neg_sign   = (c == MINUS_BYTE);
            scan_phase = PH_DIGITS;
            return;
         end
         if (!is_digit) begin
            scan_phase = PH_DONE;
            return;
         end
         scan_phase = PH_DIGITS;
      end
      if (scan_phase == PH_DIGITS) begin
         if (!is_digit) begin
            scan_phase = PH_DONE;
            return;
         end
         m = int'(mag) * 10 + int'(c - ZERO_BYTE);
         mag = (m > 65535) ? 16'hFFFF : 16'(m);
         if (holds_byte(fld_idx))
            fbytes[fld_idx-1] = 8'(fbytes[fld_idx-1] * 10 + (c - ZERO_BYTE));
      end
   endfunction

   // Feed one byte; returns 1 with the decoded command when c ends a frame.
   function automatic bit decode_frame_byte(logic [7:0] c, output frame_result_t res);
      int n_bytes;
      res = '0;
      if (c == SEP_BYTE) begin
         close_field();
         if (fld_idx < MAX_FIELDS) fld_idx++;
         return 1'b0;
      end
      if (c != END_BYTE) begin
         if (fld_idx == 0) begin
            key_byte = c;
            if (key_len < 2) key_len++;
         end else if (fld_idx < MAX_FIELDS) begin
            scan_number_byte(c);
         end
         return 1'b0;
      end

      close_field();
      n_bytes     = 0;
      res.command = CMD_NULL;
      if (key_len == 1) begin
         case (key_byte)
            KEY_MOVE:    begin res.command = CMD_MOVE;    n_bytes = 3; end
            KEY_ARM:     res.command = CMD_ARM;
            KEY_POSE:    begin res.command = CMD_POSE;    n_bytes = 6; end
            KEY_RGB:     begin res.command = CMD_RGB;     n_bytes = 3; end
            KEY_AVOID:   begin res.command = CMD_AVOID;   n_bytes = 1; end
            KEY_BALANCE: begin res.command = CMD_BALANCE; n_bytes = 1; end
            KEY_ACTION:  if (sub_one) res.command = CMD_ACTION;
            KEY_RESET:   res.command = CMD_RESET;
            default:     res.command = CMD_NULL;
         endcase
      end
      for (int i = 0; i < 6; i++)
         res.vals[i] = (i < n_bytes) ? fbytes[i] : 8'h00;
      // action group sends the group number from field 2 in value_a
      if (res.command == CMD_ACTION) res.vals[0] = fbytes[1];
      clear_decoder();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function automatic void push_byte(logic [7:0] b);
      text_byte_t t;
      t.data      = b;
      t.wait_idle = 1'b0;
      text_bytes.push_back(t);
      if (b == END_BYTE) total_frames++;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   // Any byte but the two framing bytes.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == SEP_BYTE || b == END_BYTE);
      return b;
   endfunction

   function automatic logic [7:0] space_byte();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? SPACE_BYTE : 8'(TAB_BYTE + k);
   endfunction

   // One numeric field in atoi style: spaces, sign, digits, trailing junk.
   function automatic void push_number(bit as_one);
      int roll;
      int n_digits;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         repeat ($urandom_range(1, 3)) push_byte(space_byte());
      end
      if (as_one) begin
         if ($urandom_range(0, 3) == 0) push_byte(PLUS_BYTE);
         if ($urandom_range(0, 3) == 0) push_byte(ZERO_BYTE);
         push_byte(ZERO_BYTE + 8'd1);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 15) push_byte(MINUS_BYTE);
         else if (roll < 22) push_byte(PLUS_BYTE);
         roll = $urandom_range(0, 99);
         if (roll < 8) n_digits = 0;
         else if (roll < 88) n_digits = $urandom_range(1, 3);
         else n_digits = $urandom_range(4, 8);   // big values, saturation
         repeat (n_digits) push_byte(ZERO_BYTE + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 3)) push_byte(plain_byte());
      end
   endfunction

   // A random frame, mostly well formed, some noise. Optionally the first
   // byte waits until every earlier command has come out.
   function automatic void push_random_frame(bit wait_first);
      int         start;
      int         roll;
      int         n_fields;
      logic [7:0] key;
      bit         k_one;
      start = text_bytes.size();
      roll  = $urandom_range(0, 99);
      if (roll < 8) begin
         // raw noise, framing bytes included
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         roll = $urandom_range(0, 99);
         key  = KEY_LIST[$urandom_range(0, 7)];
         if (roll < 82) push_byte(key);
         else if (roll < 90) push_byte(plain_byte());
         else if (roll < 95) begin
            push_byte(key);
            push_byte(KEY_LIST[$urandom_range(0, 7)]);
         end
         // else: empty key field
         k_one    = (key == KEY_ACTION) && ($urandom_range(0, 9) < 7);
         n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9)
                                                 : $urandom_range(0, 6);
         for (int f = 1; f <= n_fields; f++) begin
            push_byte(SEP_BYTE);
            push_number(k_one && f == 1);
         end
      end
      push_byte(END_BYTE);
      if (wait_first) text_bytes[start].wait_idle = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] MISMATCH result %0d %s: got %0h, want %0h",
                  $time, results_seen, what, got, want);
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents queued bytes, draws a gap after each accepted byte.
   // The decoder runs on every accepted byte.
   // ------------------------------------------------------------------------
   bit            offering;
   int            gap_left;
   frame_result_t decoded;
   text_byte_t    next_byte;

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         offering = 1'b0;
         gap_left = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            bytes_sent++;
            if (decode_frame_byte(req_data_byte, decoded))
               pending_results.push_back(decoded);
            offering = 1'b0;
            // every third window of 150 bytes runs back to back
            gap_left = (((bytes_sent / 150) % 3) == 1) ? 0 : $urandom_range(0, 15);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (text_bytes.size() > 0 &&
                         !(text_bytes[0].wait_idle && pending_results.size() > 0)) begin
               next_byte = text_bytes.pop_front();
               req_data_byte <= next_byte.data;
               offering = 1'b1;
            end
         end
         // single update per edge keeps valid high between back-to-back items
         req_valid <= offering;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: takes results, stalls at random, and once holds off long
   // enough for the parser to back up onto its input.
   // ------------------------------------------------------------------------
   int            stall_left;
   frame_result_t want;

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_command, 0);
            end else begin
               want = pending_results.pop_front();
               cmd_seen[int'(want.command)]++;
               check_field("command", rsp_command, want.command);
               check_field("value_a", rsp_value_a, want.vals[0]);
               check_field("value_b", rsp_value_b, want.vals[1]);
               check_field("value_c", rsp_value_c, want.vals[2]);
               check_field("value_d", rsp_value_d, want.vals[3]);
               check_field("value_e", rsp_value_e, want.vals[4]);
               check_field("value_f", rsp_value_f, want.vals[5]);
            end
            if (results_seen == HOLD_AT_RESULT)
               stall_left = LONG_HOLD;
            else
               stall_left = (((results_seen / 16) % 3) == 1) ? 0 : $urandom_range(0, 15);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: nothing moving on either channel for too long ends the run.
   // ------------------------------------------------------------------------
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no item moved for %0d cycles, %0d results pending",
                  $time, WATCHDOG_LIMIT, pending_results.size());
         $display("remote_command_frame_parser verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: build the stimulus, release reset, wait for the drain.
   // ------------------------------------------------------------------------
   int n_random;

   initial begin
      // hand-picked frames first
      push_text("C|1|2|3&");                         // move
      push_text("D|9&");                             // arm sends no data
      push_text("F|-1|255|256|-128|+7|");            // pose, byte extremes
      push_byte(SPACE_BYTE);
      push_byte(TAB_BYTE);
      push_text("42x9&");                            // trailing junk dropped
      push_text("H|0|00127|99999&");                 // large value, low byte
      push_text("I|-0&");                            // avoid
      push_text("J|65536&");                         // balance
      push_text("K|1|42&");                          // action group
      push_text("K|-1|42&");                         // minus one is not one
      push_text("K|+1| -3&");                        // sign on the sub command
      push_text("K|99999999|5&");                    // saturated sub command
      push_text("K|2|5&");                           // sub command not one
      push_text("K|1&");                             // action, group missing
      push_text("O|5|5&");                           // reset sends no data
      push_text("CC|1|2|3&");                        // key two bytes long
      push_text("|1|2&");                            // empty key
      push_text("X|1&");                             // unknown key letter
      push_text("C||7&");                            // missing field
      push_text("F|1|2|3|4|5|6|7|8|9|10&");          // fields past the limit
      push_text("C|");                               // zero byte is a non-digit
      push_byte(8'h00);
      push_text("5|");
      push_byte(8'h0B);
      push_byte(8'h0C);
      push_byte(CR_BYTE);
      push_text("-7|+-5&");
      push_text("H|1 2|3a4|- 5&");                   // digits stop at non-digit
      push_text("&");                                // bare terminator
      push_byte(8'hC3);                              // high-bit key byte
      push_text("|1&");

      // random frames; every 20th waits until the parser has drained
      n_random = 0;
      while (text_bytes.size() < BYTE_TARGET) begin
         push_random_frame((n_random % 20) == 0);
         n_random++;
      end
      total_bytes = text_bytes.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (bytes_sent < total_bytes) @(negedge clock);
      while (pending_results.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Summary: %0d bytes in %0d frames sent, %0d results checked, %0d mismatches",
               bytes_sent, total_frames, results_seen, mismatches);
      $display("Summary: by command null..reset: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
               cmd_seen[5], cmd_seen[6], cmd_seen[7], cmd_seen[8]);
      if (mismatches == 0) begin
         $display("remote_command_frame_parser verification clean");
      end else begin
         $display("remote_command_frame_parser verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rcfp_pkg.sv
rtl/rcfp_tokenizer.sv
rtl/rcfp_cmd_decode.sv
rtl/remote_command_frame_parser.sv
tb/sv/tb_top.sv
